### rtl/smi_pkg.sv
// Package for the sparse minimum intersection block.
// Holds the store dimensions, the controller state type and the command and
// status structs shared by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package smi_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int SIZE_W      = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W       = 16;
  localparam int VAL_W       = 16;
  localparam int CNT_W       = 11;
  localparam int COUNT_CAP   = (MAX_ENTRIES < 2047) ? MAX_ENTRIES : 2047;
  localparam int ENTRY_W     = IDX_W + VAL_W;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_PROBE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_EMIT
  } smi_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // store a load entry, close the load on last
    logic capture;  // latch a probe entry
    logic rd;       // read the stored entry at the scan pointer
    logic advance;  // move the scan pointer forward by one
    logic exhaust;  // mark the scan as run past the end
    logic hit;      // record a match and count it
    logic emit;     // move the result into the output register
  } smi_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic exhausted;
    logic in_range;
    logic less;
    logic equal;
    logic out_free;
  } smi_status_t;

endpackage

### rtl/smi_in_if.sv
// Input channel of the sparse minimum intersection block.
// Carries the valid/ready handshake and one load or probe entry; uses smi_pkg.
`timescale 1ns / 1ps

interface smi_in_if
  import smi_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             action;
  logic [IDX_W-1:0] entry_index;
  logic [VAL_W-1:0] entry_value;
  logic             last;

  modport source (output valid, action, entry_index, entry_value, last, input ready);
  modport sink   (input valid, action, entry_index, entry_value, last, output ready);
endinterface

### rtl/smi_out_if.sv
// Output channel of the sparse minimum intersection block.
// Carries the valid/ready handshake and one probe result; uses smi_pkg.
`timescale 1ns / 1ps

interface smi_out_if
  import smi_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             hit;
  logic [IDX_W-1:0] out_index;
  logic [VAL_W-1:0] out_value;
  logic [CNT_W-1:0] written_count;
  logic             run_done;

  modport source (output valid, hit, out_index, out_value, written_count, run_done,
                  input ready);
  modport sink   (input valid, hit, out_index, out_value, written_count, run_done,
                  output ready);
endinterface

### rtl/sparse_min_intersect.sv
// Sparse minimum intersection. Load transactions (action 0) write the second
// vector's (index, grade) entries into a 1024-entry store; the one with last
// set closes the load and rearms the scan. Probe transactions (action 1) bring
// the first vector's entries in ascending index order and each gives exactly
// one result: hit, the index and the smaller grade on a match, the running
// hit count, and run_done on the probe marked last, which also rearms the
// scan. Loads can be taken back to back. A probe holds the input off until its
// result is moved into the output register. The scan pointer steps past every
// stored entry with a smaller index, and every step is one read of the store
// followed by one compare. A probe that finds the scan already past the end,
// or runs past it, goes to the output without a further compare. While the
// output register still holds an unread result, the probe also waits for the
// sink. The store is not cleared after reset and needs no initialization pass.
`timescale 1ns / 1ps

module sparse_min_intersect
  import smi_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  smi_in_if.sink    in_i,
  smi_out_if.source out_o
);

  smi_cmd_t    cmd;
  smi_status_t status;
  logic        in_ready;

  assign in_i.ready = in_ready;

  smi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .action_i   (in_i.action),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  smi_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .entry_index_i   (in_i.entry_index),
    .entry_value_i   (in_i.entry_value),
    .last_i          (in_i.last),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .hit_o           (out_o.hit),
    .out_index_o     (out_o.out_index),
    .out_value_o     (out_o.out_value),
    .written_count_o (out_o.written_count),
    .run_done_o      (out_o.run_done)
  );

endmodule

### rtl/smi_ram.sv
// Generic single write port, single read port RAM with a registered read.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module smi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/smi_datapath.sv
// Datapath of the sparse minimum intersection block: entry store, fill and
// scan pointers, hit counter and output register. Uses smi_pkg and smi_ram.
`timescale 1ns / 1ps

module smi_datapath
  import smi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smi_cmd_t          cmd_i,
  output smi_status_t       status_o,
  input  logic [IDX_W-1:0]  entry_index_i,
  input  logic [VAL_W-1:0]  entry_value_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              hit_o,
  output logic [IDX_W-1:0]  out_index_o,
  output logic [VAL_W-1:0]  out_value_o,
  output logic [CNT_W-1:0]  written_count_o,
  output logic              run_done_o
);

  logic [SIZE_W-1:0] fill_q, fill_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [SIZE_W-1:0] scan_q, scan_d;
  logic              exh_q, exh_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q, out_valid_d;

  logic [IDX_W-1:0]  ix_q;
  logic [VAL_W-1:0]  val_q;
  logic              last_q;
  logic              res_hit_q;
  logic [VAL_W-1:0]  res_val_q;

  logic [ENTRY_W-1:0] rdata;
  logic [IDX_W-1:0]   stored_ix;
  logic [VAL_W-1:0]   stored_val;
  logic               has_room;
  logic [SIZE_W-1:0]  kept;

  assign has_room   = fill_q < SIZE_W'(MAX_ENTRIES);
  assign kept       = fill_q + SIZE_W'(has_room);
  assign stored_ix  = rdata[ENTRY_W-1:VAL_W];
  assign stored_val = rdata[VAL_W-1:0];

  smi_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && has_room),
    .waddr_i (fill_q[ADDR_W-1:0]),
    .wdata_i ({entry_index_i, entry_value_i}),
    .re_i    (cmd_i.rd),
    .raddr_i (scan_q[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    fill_d      = fill_q;
    size_d      = size_q;
    scan_d      = scan_q;
    exh_d       = exh_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_i.load) begin
      fill_d = kept;
      if (last_i) begin
        size_d  = kept;
        fill_d  = '0;
        scan_d  = '0;
        exh_d   = 1'b0;
        count_d = '0;
      end
    end
    if (cmd_i.advance) begin
      scan_d = scan_q + SIZE_W'(1);
    end
    if (cmd_i.exhaust) begin
      exh_d = 1'b1;
    end
    if (cmd_i.hit && (count_q < CNT_W'(COUNT_CAP))) begin
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      // The last probe of a run rearms the scan once its count is reported.
      if (last_q) begin
        scan_d  = '0;
        exh_d   = 1'b0;
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      size_q      <= '0;
      scan_q      <= '0;
      exh_q       <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      size_q      <= size_d;
      scan_q      <= scan_d;
      exh_q       <= exh_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ix_q      <= entry_index_i;
      val_q     <= entry_value_i;
      last_q    <= last_i;
      res_hit_q <= 1'b0;
      res_val_q <= '0;
    end else if (cmd_i.hit) begin
      res_hit_q <= 1'b1;
      res_val_q <= (stored_val < val_q) ? stored_val : val_q;
    end
    if (cmd_i.emit) begin
      hit_o           <= res_hit_q;
      out_index_o     <= res_hit_q ? ix_q : '0;
      out_value_o     <= res_val_q;
      written_count_o <= count_q;
      run_done_o      <= last_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.exhausted = exh_q;
  assign status_o.in_range  = scan_q < size_q;
  assign status_o.less      = stored_ix < ix_q;
  assign status_o.equal     = stored_ix == ix_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  a_scan_within_size : assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q <= size_q)
    else $error("scan pointer ran past the stored length");

  a_size_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q <= SIZE_W'(MAX_ENTRIES) && fill_q <= SIZE_W'(MAX_ENTRIES))
    else $error("stored length or fill pointer exceeds the store");

  a_count_capped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(COUNT_CAP))
    else $error("hit count exceeds its cap");

  a_hit_needs_live_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.hit |-> (!exh_q && status_o.in_range))
    else $error("hit recorded on an exhausted scan");

  a_emit_into_free_reg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> status_o.out_free)
    else $error("result overwrote an unread output");

endmodule

### rtl/smi_ctrl.sv
// Controller of the sparse minimum intersection block: accepts entries and
// steps each probe through the merge scan. Uses smi_pkg.
`timescale 1ns / 1ps

module smi_ctrl
  import smi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        action_i,
  output logic        in_ready_o,
  input  smi_status_t status_i,
  output smi_cmd_t    cmd_o
);

  smi_state_e state_q, state_d;
  logic       accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    accept     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        accept     = in_valid_i;
        if (accept && (action_i == ACT_LOAD)) begin
          cmd_o.load = 1'b1;
        end else if (accept && (action_i == ACT_PROBE)) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_READ: begin
        if (status_i.exhausted) begin
          state_d = ST_EMIT;
        end else if (!status_i.in_range) begin
          cmd_o.exhaust = 1'b1;
          state_d       = ST_EMIT;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = ST_CMP;
        end
      end
      ST_CMP: begin
        if (status_i.less) begin
          cmd_o.advance = 1'b1;
          state_d       = ST_READ;
        end else begin
          cmd_o.hit = status_i.equal;
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_read_then_compare : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |=> state_q == ST_CMP)
    else $error("stored entry read without a compare step");

  a_probe_leads_to_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == ST_READ && !in_ready_o))
    else $error("probe accepted without starting the scan");

  a_one_datapath_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.capture, cmd_o.rd, cmd_o.advance, cmd_o.emit}))
    else $error("conflicting datapath commands");

endmodule

### sim/testbench.sv
// Self-checking testbench for sparse_min_intersect: drives load and probe
// transactions, predicts every probe result and checks it at the output.
// Depends on smi_pkg, smi_in_if, smi_out_if and the sparse_min_intersect RTL.
`timescale 1ns / 1ps

module testbench;
  import smi_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int HOLD_CYCLES    = 400;
  localparam int ITEM_TARGET    = 1650;

  typedef struct packed {
    logic             action;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] grade;
    logic             last;
  } entry_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] grade;
    logic [CNT_W-1:0] count;
    logic             done;
  } match_t;

  logic clk_i;
  logic rst_ni;

  smi_in_if  in_bus ();
  smi_out_if out_bus ();

  sparse_min_intersect dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  entry_t pending_entries[$];
  match_t expected_matches[$];

  // Shadow copy of the block's store and scan state.
  logic [IDX_W-1:0] shadow_index [MAX_ENTRIES];
  logic [VAL_W-1:0] shadow_grade [MAX_ENTRIES];
  int   shadow_size  = 0;
  int   shadow_fill  = 0;
  int   shadow_scan  = 0;
  bit   shadow_spent = 1'b0;
  int   shadow_hits  = 0;

  int   mismatches   = 0;
  int   items_taken  = 0;
  int   results_seen = 0;
  int   hits_checked = 0;
  int   peak_count   = 0;

  logic in_fire  = 1'b0;
  logic out_fire = 1'b0;
  logic hold_off = 1'b0;

  entry_t src_item;
  bit     src_busy = 1'b0;
  bit     src_calm = 1'b0;
  int     src_gap  = 0;
  int     src_sent = 0;
  bit     snk_calm = 1'b0;
  int     snk_gap  = 0;
  int     snk_taken = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic int pick_grade();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 0;
    if (r == 1) return 16'hFFFF;
    return $urandom_range(0, 16'hFFFF);
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%s", what);
  endtask

  // Advances the shadow state by one accepted transaction and queues the
  // result a probe is expected to produce.
  task automatic track_entry(input entry_t e);
    match_t r;
    r = '0;
    if (e.action == ACT_LOAD) begin
      if (shadow_fill < MAX_ENTRIES) begin
        shadow_index[shadow_fill] = e.index;
        shadow_grade[shadow_fill] = e.grade;
        shadow_fill++;
      end
      if (e.last) begin
        shadow_size  = shadow_fill;
        shadow_fill  = 0;
        shadow_scan  = 0;
        shadow_spent = 1'b0;
        shadow_hits  = 0;
      end
    end else begin
      if (!shadow_spent) begin
        while (shadow_scan < shadow_size && shadow_index[shadow_scan] < e.index)
          shadow_scan++;
        if (shadow_scan >= shadow_size) begin
          shadow_spent = 1'b1;
        end else if (shadow_index[shadow_scan] == e.index) begin
          r.hit   = 1'b1;
          r.index = e.index;
          r.grade = (shadow_grade[shadow_scan] < e.grade) ? shadow_grade[shadow_scan]
                                                          : e.grade;
          if (shadow_hits < COUNT_CAP) shadow_hits++;
        end
      end
      r.count = shadow_hits[CNT_W-1:0];
      r.done  = e.last;
      expected_matches = {expected_matches, r};
      if (shadow_hits > peak_count) peak_count = shadow_hits;
      if (e.last) begin
        shadow_scan  = 0;
        shadow_spent = 1'b0;
        shadow_hits  = 0;
      end
    end
  endtask

  task automatic queue_entry(input logic act, input int idx, input int val, input bit fin);
    entry_t e;
    e.action = act;
    e.index  = idx[IDX_W-1:0];
    e.grade  = val[VAL_W-1:0];
    e.last   = fin;
    pending_entries = {pending_entries, e};
  endtask

  task automatic queue_directed();
    // Probes on an empty store find the scan exhausted.
    queue_entry(ACT_PROBE, 16'h0000, 16'hFFFF, 1'b0);
    queue_entry(ACT_PROBE, 16'hFFFF, 16'h0000, 1'b1);
    queue_entry(ACT_LOAD, 16'h0000, 16'hFFFF, 1'b0);
    queue_entry(ACT_LOAD, 7, 16'h0001, 1'b0);
    queue_entry(ACT_LOAD, 100, 16'h8000, 1'b0);
    queue_entry(ACT_LOAD, 16'hFFFF, 16'h0000, 1'b1);
    queue_entry(ACT_PROBE, 16'h0000, 16'h1234, 1'b0);
    // The same index again hits the same stored entry.
    queue_entry(ACT_PROBE, 16'h0000, 16'hFFFF, 1'b0);
    queue_entry(ACT_PROBE, 3, 16'h5555, 1'b0);
    queue_entry(ACT_PROBE, 7, 16'hFFFF, 1'b0);
    queue_entry(ACT_PROBE, 100, 16'h7FFF, 1'b0);
    queue_entry(ACT_PROBE, 200, 16'hAAAA, 1'b0);
    queue_entry(ACT_PROBE, 16'hFFFF, 16'hFFFF, 1'b1);
    // Run past the end, then come back with a smaller index.
    queue_entry(ACT_LOAD, 10, 16'hAAAA, 1'b1);
    queue_entry(ACT_PROBE, 20, 16'h1111, 1'b0);
    queue_entry(ACT_PROBE, 10, 16'h2222, 1'b0);
    queue_entry(ACT_PROBE, 10, 16'h3333, 1'b1);
    queue_entry(ACT_PROBE, 10, 16'h5555, 1'b1);
    // A probe while a load is open uses the old length.
    queue_entry(ACT_LOAD, 30, 16'h1111, 1'b0);
    queue_entry(ACT_PROBE, 10, 16'hFFFF, 1'b1);
    queue_entry(ACT_LOAD, 40, 16'h0F0F, 1'b1);
  endtask

  // Overfills the store and scans deep into it.
  task automatic queue_full_store();
    int lo;
    for (int i = 0; i < MAX_ENTRIES + 6; i++)
      queue_entry(ACT_LOAD, i * 60, pick_grade(), i == MAX_ENTRIES + 5);
    lo = 0;
    while (lo <= 60 * (MAX_ENTRIES - 1)) begin
      queue_entry(ACT_PROBE, lo, pick_grade(), 1'b0);
      lo += 30 * $urandom_range(1, 50);
    end
    // Index of an entry that was dropped because the store was full.
    queue_entry(ACT_PROBE, 60 * MAX_ENTRIES, pick_grade(), 1'b1);
  endtask

  task automatic queue_matched_run(input int n);
    int keys[$];
    int probes[$];
    int cur;
    int lo;
    cur = $urandom_range(0, 65535 - 17 * n);
    for (int i = 0; i < n; i++) begin
      keys = {keys, cur};
      queue_entry(ACT_LOAD, cur, pick_grade(), i == n - 1);
      cur += ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 16);
    end
    lo = 0;
    foreach (keys[j]) begin
      if ($urandom_range(0, 2) == 0 && keys[j] > lo) begin
        lo = $urandom_range(lo, keys[j] - 1);
        probes = {probes, lo};
      end
      if ($urandom_range(0, 1) == 0) begin
        lo = keys[j];
        probes = {probes, lo};
      end
    end
    if ($urandom_range(0, 1) == 0) probes = {probes, int'($urandom_range(lo, 65535))};
    if (probes.size() == 0) probes = {probes, lo};
    foreach (probes[j])
      queue_entry(ACT_PROBE, probes[j], pick_grade(), j == probes.size() - 1);
  endtask

  // Loads interleaved with probes, followed by an unsorted probe run.
  task automatic queue_tangled_run(input int n);
    int keys[$];
    int cur;
    cur = $urandom_range(0, 65535 - 20 * n);
    for (int i = 0; i < n; i++) begin
      keys = {keys, cur};
      queue_entry(ACT_LOAD, cur, pick_grade(), i == n - 1);
      if ($urandom_range(0, 2) == 0)
        queue_entry(ACT_PROBE, $urandom_range(0, 65535), pick_grade(),
                    $urandom_range(0, 5) == 0);
      cur += $urandom_range(0, 20);
    end
    for (int i = 0; i < n; i++)
      queue_entry(ACT_PROBE, keys[$urandom_range(0, n - 1)], pick_grade(), i == n - 1);
  endtask

  task automatic queue_noise(input int n);
    for (int i = 0; i < n; i++)
      queue_entry($urandom_range(0, 1) ? ACT_PROBE : ACT_LOAD, $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 7) == 0);
  endtask

  // Driver: one transaction offered at a time, with a random gap after each.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (src_busy && in_fire) begin
        src_busy = 1'b0;
        src_sent++;
        if (src_sent % 40 == 0) src_calm = ($urandom_range(0, 3) == 0);
        src_gap = draw_wait(src_calm);
      end
      if (!src_busy && src_gap > 0) begin
        src_gap--;
        in_bus.valid <= 1'b0;
      end else if (!src_busy && pending_entries.size() > 0) begin
        src_item = pending_entries.pop_front();
        in_bus.valid       <= 1'b1;
        in_bus.action      <= src_item.action;
        in_bus.entry_index <= src_item.index;
        in_bus.entry_value <= src_item.grade;
        in_bus.last        <= src_item.last;
        src_busy = 1'b1;
      end else if (!src_busy) begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Result sink: random stall after every accepted result.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_fire) begin
        snk_taken++;
        if (snk_taken % 40 == 0) snk_calm = ($urandom_range(0, 3) == 0);
        snk_gap = draw_wait(snk_calm);
      end
      if (snk_gap > 0) begin
        snk_gap--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= !hold_off;
      end
    end
  end

  // Long back-pressure windows so the block fills up and stalls its input.
  initial begin
    while (results_seen < 150) @(negedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    hold_off <= 1'b0;
    while (results_seen < 1500) @(negedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    hold_off <= 1'b0;
  end

  // Monitor: checks results against the oldest expectation, then predicts.
  always @(posedge clk_i) begin
    match_t got;
    match_t want;
    entry_t seen;
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        results_seen++;
        got.hit   = out_bus.hit;
        got.index = out_bus.out_index;
        got.grade = out_bus.out_value;
        got.count = out_bus.written_count;
        got.done  = out_bus.run_done;
        if (expected_matches.size() == 0) begin
          note_mismatch($sformatf("unexpected result: hit=%0b idx=%h val=%h cnt=%0d done=%0b",
                                  got.hit, got.index, got.grade, got.count, got.done));
        end else begin
          want = expected_matches.pop_front();
          if (want.hit) hits_checked++;
          if (got !== want)
            note_mismatch($sformatf({"mismatch: expected hit=%0b idx=%h val=%h cnt=%0d done=%0b",
                                     ", got hit=%0b idx=%h val=%h cnt=%0d done=%0b"},
                                    want.hit, want.index, want.grade, want.count, want.done,
                                    got.hit, got.index, got.grade, got.count, got.done));
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        items_taken++;
        seen.action = in_bus.action;
        seen.index  = in_bus.entry_index;
        seen.grade  = in_bus.entry_value;
        seen.last   = in_bus.last;
        track_entry(seen);
      end
    end
    in_fire  <= in_bus.valid && in_bus.ready;
    out_fire <= out_bus.valid && out_bus.ready;
  end

  // Watchdog on cycles without any accepted transaction.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_matches.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int target;
    int pick;
    rst_ni             = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.action      = ACT_LOAD;
    in_bus.entry_index = '0;
    in_bus.entry_value = '0;
    in_bus.last        = 1'b0;
    out_bus.ready      = 1'b0;

    queue_directed();
    queue_full_store();
    target = ITEM_TARGET;
    while (pending_entries.size() < target) begin
      pick = $urandom_range(0, 19);
      if (pick < 14)
        queue_matched_run(($urandom_range(0, 9) == 0) ? $urandom_range(21, 300)
                                                       : $urandom_range(1, 20));
      else if (pick < 17)
        queue_tangled_run($urandom_range(1, 12));
      else
        queue_noise($urandom_range(1, 10));
    end

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_entries.size() != 0 || src_busy) @(posedge clk_i);
    while (expected_matches.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    mismatches += expected_matches.size();

    $display("summary: %0d transactions in, %0d probe results checked, %0d of them hits",
             items_taken, results_seen, hits_checked);
    $display("summary: highest hit count %0d, %0d mismatches", peak_count, mismatches);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
